FILE: design/quaternion_gyro_integrator_macros.svh
// assertion helpers shared by the checker
`ifndef QUATERNION_GYRO_INTEGRATOR_MACROS_SVH
`define QUATERNION_GYRO_INTEGRATOR_MACROS_SVH

// checked only while out of reset
`define QGI_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define QGI_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/qgi_pkg.sv
package qgi_pkg;

    localparam int QUAT_WIDTH_DEF  = 32;
    localparam int GYRO_W          = 16;
    localparam int GAIN_W          = 24;
    localparam int RATE_W          = 40;
    localparam int GAIN_SHIFT      = 40;
    localparam int DIGIT_W         = 8;
    localparam logic [GAIN_W-1:0] STEP_GAIN_RESET = 24'd2924735;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ACC_INIT,
        ST_MUL_LOAD,
        ST_MUL_RUN,
        ST_ACC_ADD,
        ST_COMP_WR,
        ST_SQ_LOAD,
        ST_SQ_RUN,
        ST_SQ_ADD,
        ST_SQRT_INIT,
        ST_SQRT_RUN,
        ST_CHECK,
        ST_DIV_LOAD,
        ST_DIV_RUN,
        ST_DIV_WR,
        ST_IDENT,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_ACC_INIT,
        DP_MUL_TERM,
        DP_MUL_SQ,
        DP_MUL_STEP,
        DP_ACC_ADD,
        DP_COMP_WR,
        DP_SQ_ADD,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_DIV_LOAD,
        DP_DIV_STEP,
        DP_DIV_WR,
        DP_IDENT,
        DP_OUT_LOAD
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [1:0] comp;
        logic [1:0] term;
    } dp_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic out_full;
    } dp_stat_t;

    // which component, which rate and which sign feed one product term
    typedef struct packed {
        logic [1:0] qi;
        logic [1:0] ai;
        logic       neg;
    } term_sel_t;

    function automatic term_sel_t term_sel(input logic [1:0] comp, input logic [1:0] term);
        term_sel_t r;
        unique case ({comp, term})
            4'h0:    r = '{qi: 2'd1, ai: 2'd0, neg: 1'b1};
            4'h1:    r = '{qi: 2'd2, ai: 2'd1, neg: 1'b1};
            4'h2:    r = '{qi: 2'd3, ai: 2'd2, neg: 1'b1};
            4'h4:    r = '{qi: 2'd0, ai: 2'd0, neg: 1'b0};
            4'h5:    r = '{qi: 2'd2, ai: 2'd2, neg: 1'b0};
            4'h6:    r = '{qi: 2'd3, ai: 2'd1, neg: 1'b1};
            4'h8:    r = '{qi: 2'd0, ai: 2'd1, neg: 1'b0};
            4'h9:    r = '{qi: 2'd1, ai: 2'd2, neg: 1'b1};
            4'hA:    r = '{qi: 2'd3, ai: 2'd0, neg: 1'b0};
            4'hC:    r = '{qi: 2'd0, ai: 2'd2, neg: 1'b0};
            4'hD:    r = '{qi: 2'd1, ai: 2'd1, neg: 1'b0};
            4'hE:    r = '{qi: 2'd2, ai: 2'd0, neg: 1'b1};
            default: r = '{qi: 2'd0, ai: 2'd0, neg: 1'b0};
        endcase
        return r;
    endfunction

endpackage

FILE: design/qgi_ctrl.sv
module qgi_ctrl #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output qgi_pkg::dp_cmd_t  cmd,
    input  qgi_pkg::dp_stat_t stat
);
    import qgi_pkg::*;

    localparam int W         = QUAT_WIDTH;
    localparam int MB        = (W > RATE_W) ? W : RATE_W;
    localparam int MUL_STEPS = (MB + DIGIT_W - 1) / DIGIT_W;
    localparam int CNT_W     = $clog2(W + 2);
    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(MUL_STEPS - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(W);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(W - 2);

    state_t           state_reg, state_next;
    logic [1:0]       comp_reg, comp_next;
    logic [1:0]       term_reg, term_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            comp_reg  <= '0;
            term_reg  <= '0;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            comp_reg  <= comp_next;
            term_reg  <= term_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        comp_next  = comp_reg;
        term_next  = term_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_ACC_INIT;
                    comp_next  = '0;
                end
            end
            ST_ACC_INIT: begin
                term_next  = '0;
                state_next = ST_MUL_LOAD;
            end
            ST_MUL_LOAD: begin
                cnt_next   = '0;
                state_next = ST_MUL_RUN;
            end
            ST_MUL_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_ACC_ADD;
                end
            end
            ST_ACC_ADD: begin
                if (term_reg == 2'd2) begin
                    state_next = ST_COMP_WR;
                end else begin
                    term_next  = term_reg + 1'b1;
                    state_next = ST_MUL_LOAD;
                end
            end
            ST_COMP_WR: begin
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd3) begin
                    state_next = ST_SQ_LOAD;
                end else begin
                    state_next = ST_ACC_INIT;
                end
            end
            ST_SQ_LOAD: begin
                cnt_next   = '0;
                state_next = ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == MUL_LAST) begin
                    state_next = ST_SQ_ADD;
                end
            end
            ST_SQ_ADD: begin
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd3) begin
                    state_next = ST_SQRT_INIT;
                end else begin
                    state_next = ST_SQ_LOAD;
                end
            end
            ST_SQRT_INIT: begin
                cnt_next   = '0;
                state_next = ST_SQRT_RUN;
            end
            ST_SQRT_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == SQRT_LAST) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                comp_next = '0;
                if (stat.n_zero) begin
                    state_next = ST_IDENT;
                end else begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_DIV_LOAD: begin
                cnt_next   = '0;
                state_next = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = ST_DIV_WR;
                end
            end
            ST_DIV_WR: begin
                comp_next = comp_reg + 1'b1;
                if (comp_reg == 2'd3) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_DIV_LOAD;
                end
            end
            ST_IDENT: begin
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!stat.out_full) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.op   = DP_NOP;
        cmd.comp = comp_reg;
        cmd.term = term_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = DP_LOAD;
                end
            end
            ST_ACC_INIT:  cmd.op = DP_ACC_INIT;
            ST_MUL_LOAD:  cmd.op = DP_MUL_TERM;
            ST_MUL_RUN:   cmd.op = DP_MUL_STEP;
            ST_ACC_ADD:   cmd.op = DP_ACC_ADD;
            ST_COMP_WR:   cmd.op = DP_COMP_WR;
            ST_SQ_LOAD:   cmd.op = DP_MUL_SQ;
            ST_SQ_RUN:    cmd.op = DP_MUL_STEP;
            ST_SQ_ADD:    cmd.op = DP_SQ_ADD;
            ST_SQRT_INIT: cmd.op = DP_SQRT_INIT;
            ST_SQRT_RUN:  cmd.op = DP_SQRT_STEP;
            ST_CHECK:     cmd.op = DP_NOP;
            ST_DIV_LOAD:  cmd.op = DP_DIV_LOAD;
            ST_DIV_RUN:   cmd.op = DP_DIV_STEP;
            ST_DIV_WR:    cmd.op = DP_DIV_WR;
            ST_IDENT:     cmd.op = DP_IDENT;
            ST_OUT: begin
                if (!stat.out_full) begin
                    cmd.op = DP_OUT_LOAD;
                end
            end
            default:      cmd.op = DP_NOP;
        endcase
    end

endmodule

FILE: design/qgi_datapath.sv
module qgi_datapath #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  qgi_pkg::dp_cmd_t                   cmd,
    output qgi_pkg::dp_stat_t                  stat,
    input  logic                               cfg_we,
    input  logic [qgi_pkg::GAIN_W-1:0]         cfg_step_gain,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_x,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_y,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_z,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_w,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_x,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_y,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_z
);
    import qgi_pkg::*;

    localparam int W    = QUAT_WIDTH;
    localparam int F    = W - 2;
    localparam int MB   = (W > RATE_W) ? W : RATE_W;
    localparam int MBP  = ((MB + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int PW   = W + MBP;
    localparam int AW   = PW + 2;
    localparam int SUMW = AW - GAIN_SHIFT + 1;
    localparam int SW   = 2 * W + 2;
    localparam int RW   = W + 3;
    localparam int Q    = W - 1;
    localparam int NW   = 2 * W + 1;
    localparam int DW   = W + 2;
    localparam logic [AW-1:0] ACC_HALF = AW'(1) << (GAIN_SHIFT - 1);
    localparam logic [W-1:0]  Q_ONE    = W'(1) << F;
    localparam logic [W-1:0]  Q_MAX    = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  Q_MIN    = {1'b1, {(W-1){1'b0}}};

    logic [GAIN_W-1:0]        gain_reg;
    logic [RATE_W-1:0]        rate_reg [3];
    logic [W-1:0]             att_reg [4];
    logic [W-1:0]             att_next [4];
    logic [W-1:0]             mul_a_reg;
    logic [MBP-1:0]           mul_b_reg;
    logic [PW-1:0]            prod_reg;
    logic                     prod_neg_reg;
    logic [AW-1:0]            acc_reg;
    logic [SW-1:0]            sq_reg;
    logic [SW-1:0]            sqrt_sh_reg;
    logic [RW-1:0]            sqrt_rem_reg;
    logic [W:0]               root_reg;
    logic [DW-1:0]            div_rem_reg;
    logic [Q-1:0]             div_low_reg;
    logic [Q-1:0]             quo_reg;
    logic                     div_neg_reg;
    logic [W-1:0]             out_reg [4];
    logic                     m_valid_reg;

    term_sel_t                sel;
    logic [1:0]               rd_idx;
    logic [W-1:0]             q_rd;
    logic [W-1:0]             q_mag;
    logic [RATE_W-1:0]        a_rd;
    logic [RATE_W-1:0]        a_mag;
    logic signed [RATE_W:0]   ax_full, ay_full, az_full;
    logic [W+DIGIT_W-1:0]     pp;
    logic [AW-1:0]            prod_ext;
    logic signed [SUMW-1:0]   upd_sum;
    logic [W-1:0]             upd_sat;
    logic [RW+1:0]            sq_rem2;
    logic [RW+1:0]            sq_trial;
    logic                     sq_ge;
    logic [NW-1:0]            div_num;
    logic [DW:0]              div_r2;
    logic [DW:0]              div_den;
    logic                     div_ge;
    logic [W-1:0]             div_mag;

    assign sel    = term_sel(cmd.comp, cmd.term);
    assign rd_idx = (cmd.op == DP_MUL_TERM) ? sel.qi : cmd.comp;
    assign q_rd   = att_reg[rd_idx];
    assign q_mag  = q_rd[W-1] ? (~q_rd + 1'b1) : q_rd;
    assign a_rd   = rate_reg[sel.ai];
    assign a_mag  = a_rd[RATE_W-1] ? (~a_rd + 1'b1) : a_rd;

    // angle increments for the three axes
    assign ax_full = s_gyro_x * $signed({1'b0, gain_reg});
    assign ay_full = s_gyro_y * $signed({1'b0, gain_reg});
    assign az_full = s_gyro_z * $signed({1'b0, gain_reg});

    // one digit of the shared multiplier, msb first
    assign pp       = mul_a_reg * mul_b_reg[MBP-1 -: DIGIT_W];
    assign prod_ext = AW'(prod_reg);

    // integrated component, rounded and clamped
    assign upd_sum = SUMW'($signed(q_rd)) + SUMW'($signed(acc_reg[AW-1:GAIN_SHIFT]));
    always_comb begin
        if (upd_sum[SUMW-1:W-1] == '0 || upd_sum[SUMW-1:W-1] == '1) begin
            upd_sat = upd_sum[W-1:0];
        end else if (upd_sum[SUMW-1]) begin
            upd_sat = Q_MIN;
        end else begin
            upd_sat = Q_MAX;
        end
    end

    // restoring square root, two bits of the sum per step
    assign sq_rem2  = {sqrt_rem_reg, sqrt_sh_reg[SW-1:SW-2]};
    assign sq_trial = (RW+2)'({root_reg, 2'b01});
    assign sq_ge    = sq_rem2 >= sq_trial;

    // restoring divide by twice the root, one quotient bit per step
    assign div_num = (NW'(q_mag) << (F + 1)) + NW'(root_reg);
    assign div_r2  = {div_rem_reg, div_low_reg[Q-1]};
    assign div_den = (DW+1)'({root_reg, 1'b0});
    assign div_ge  = div_r2 >= div_den;
    assign div_mag = W'(quo_reg);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            att_next[k] = att_reg[k];
        end
        case (cmd.op)
            DP_COMP_WR: att_next[cmd.comp] = upd_sat;
            DP_DIV_WR:  att_next[cmd.comp] = div_neg_reg ? (~div_mag + 1'b1) : div_mag;
            DP_IDENT: begin
                att_next[0] = Q_ONE;
                att_next[1] = '0;
                att_next[2] = '0;
                att_next[3] = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg    <= STEP_GAIN_RESET;
            att_reg[0]  <= Q_ONE;
            att_reg[1]  <= '0;
            att_reg[2]  <= '0;
            att_reg[3]  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                gain_reg <= cfg_step_gain;
            end
            for (int k = 0; k < 4; k++) begin
                att_reg[k] <= att_next[k];
            end
            if (cmd.op == DP_OUT_LOAD) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            DP_LOAD: begin
                rate_reg[0] <= ax_full[RATE_W-1:0];
                rate_reg[1] <= ay_full[RATE_W-1:0];
                rate_reg[2] <= az_full[RATE_W-1:0];
            end
            DP_ACC_INIT: acc_reg <= ACC_HALF;
            DP_MUL_TERM: begin
                mul_a_reg    <= q_mag;
                mul_b_reg    <= MBP'(a_mag);
                prod_reg     <= '0;
                prod_neg_reg <= q_rd[W-1] ^ a_rd[RATE_W-1] ^ sel.neg;
            end
            DP_MUL_SQ: begin
                mul_a_reg    <= q_mag;
                mul_b_reg    <= MBP'(q_mag);
                prod_reg     <= '0;
                prod_neg_reg <= 1'b0;
            end
            DP_MUL_STEP: begin
                prod_reg  <= {prod_reg[PW-DIGIT_W-1:0], DIGIT_W'(0)} + PW'(pp);
                mul_b_reg <= {mul_b_reg[MBP-DIGIT_W-1:0], DIGIT_W'(0)};
            end
            DP_ACC_ADD: acc_reg <= prod_neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
            DP_COMP_WR: sq_reg  <= '0;
            DP_SQ_ADD:  sq_reg  <= sq_reg + SW'(prod_reg);
            DP_SQRT_INIT: begin
                sqrt_sh_reg  <= sq_reg;
                sqrt_rem_reg <= '0;
                root_reg     <= '0;
            end
            DP_SQRT_STEP: begin
                sqrt_rem_reg <= sq_ge ? RW'(sq_rem2 - sq_trial) : RW'(sq_rem2);
                root_reg     <= {root_reg[W-1:0], sq_ge};
                sqrt_sh_reg  <= {sqrt_sh_reg[SW-3:0], 2'b00};
            end
            DP_DIV_LOAD: begin
                div_rem_reg <= div_num[NW-1:Q];
                div_low_reg <= div_num[Q-1:0];
                quo_reg     <= '0;
                div_neg_reg <= q_rd[W-1];
            end
            DP_DIV_STEP: begin
                div_rem_reg <= div_ge ? DW'(div_r2 - div_den) : DW'(div_r2);
                div_low_reg <= {div_low_reg[Q-2:0], 1'b0};
                quo_reg     <= {quo_reg[Q-2:0], div_ge};
            end
            DP_OUT_LOAD: begin
                for (int k = 0; k < 4; k++) begin
                    out_reg[k] <= att_reg[k];
                end
            end
            default: ;
        endcase
    end

    assign stat.n_zero   = (root_reg == '0);
    assign stat.out_full = m_valid_reg && !m_ready;

    assign m_valid  = m_valid_reg;
    assign m_quat_w = out_reg[0];
    assign m_quat_x = out_reg[1];
    assign m_quat_y = out_reg[2];
    assign m_quat_z = out_reg[3];

endmodule

FILE: design/quaternion_gyro_integrator.sv
// Integrates one raw three-axis gyro beat into an attitude quaternion held in
// signed fixed point with two integer bits, then scales it to unit length and
// returns it as one result beat. Each axis count times step_gain is the angle
// increment in 2^-40 rad; w is updated first and the new w feeds x, y and z.
// Sixteen products go through one shared multiplier taking eight bits of an
// operand per cycle, the root takes one bit per cycle and the four divides
// by the root take one quotient bit per cycle. A zero-length quaternion snaps
// back to identity and skips the divides. One item is in work at a time; the
// next beat is taken as soon as a result sits in the output register, even if
// it has not been collected. step_gain may only be written while idle.
module quaternion_gyro_integrator #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [qgi_pkg::GAIN_W-1:0]         cfg_step_gain,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_x,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_y,
    input  logic signed [qgi_pkg::GYRO_W-1:0]  s_gyro_z,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_w,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_x,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_y,
    output logic signed [QUAT_WIDTH-1:0]       m_quat_z
);
    import qgi_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    qgi_ctrl #(
        .QUAT_WIDTH(QUAT_WIDTH)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .stat    (stat)
    );

    qgi_datapath #(
        .QUAT_WIDTH(QUAT_WIDTH)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_we),
        .cfg_step_gain (cfg_step_gain),
        .s_gyro_x      (s_gyro_x),
        .s_gyro_y      (s_gyro_y),
        .s_gyro_z      (s_gyro_z),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_quat_w      (m_quat_w),
        .m_quat_x      (m_quat_x),
        .m_quat_y      (m_quat_y),
        .m_quat_z      (m_quat_z)
    );

endmodule

FILE: design/qgi_checker.sv
`include "quaternion_gyro_integrator_macros.svh"

module qgi_checker #(
    parameter int QUAT_WIDTH = qgi_pkg::QUAT_WIDTH_DEF
) (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic signed [QUAT_WIDTH-1:0] m_quat_w
);

    // after reset the block is empty and ready for a beat
    `QGI_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> (s_ready && !m_valid), "bad state after reset")

    // one item in work at a time
    `QGI_ASSERT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready) |=> !s_ready, "ready while busy")

    // a fresh result frees the input side in the same cycle
    `QGI_ASSERT(a_ready_with_result, aclk, aresetn, $rose(m_valid) |-> s_ready, "result without ready")

    // a waiting result holds its value
    `QGI_ASSERT(a_result_held, aclk, aresetn, (m_valid && !m_ready) |=> (m_valid && $stable(m_quat_w)), "result dropped")

endmodule

bind quaternion_gyro_integrator qgi_checker #(.QUAT_WIDTH(QUAT_WIDTH)) u_qgi_checker (.*);

FILE: sim/quaternion_gyro_checker.sv
module quaternion_gyro_checker (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qgi_pkg::GAIN_W-1:0]        cfg_step_gain,
    input  logic                              s_valid,
    input  logic                              s_ready,
    input  logic signed [qgi_pkg::GYRO_W-1:0] s_gyro_x,
    input  logic signed [qgi_pkg::GYRO_W-1:0] s_gyro_y,
    input  logic signed [qgi_pkg::GYRO_W-1:0] s_gyro_z,
    input  logic                              m_valid,
    input  logic                              m_ready,
    input  logic signed [31:0]                m_quat_w,
    input  logic signed [31:0]                m_quat_x,
    input  logic signed [31:0]                m_quat_y,
    input  logic signed [31:0]                m_quat_z,
    output int                                errors,
    output int                                pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [127:0] wide_t;
    typedef struct {
        logic signed [31:0] w;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } quat_t;

    localparam logic signed [31:0] Q_ONE = 32'sd1 <<< 30;

    quat_t                     attitude;
    logic [qgi_pkg::GAIN_W-1:0] gain;
    quat_t                     attitude_q[$];

    function automatic wide_t rate_sum(input wide_t p, input wide_t a, input wide_t q,
                                       input wide_t b, input wide_t r, input wide_t c);
        wide_t s;
        s = p * a + q * b + r * c + (128'sd1 <<< 39);
        return s >>> 40;
    endfunction

    function automatic logic signed [31:0] clamp32(input wide_t v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] unit_scale(input logic signed [31:0] q,
                                                      input logic [127:0] n);
        logic [127:0] mag;
        logic [127:0] quo;
        wide_t        wq;
        wq  = q;
        mag = (wq < 0) ? -wq : wq;
        quo = ((mag << 31) + n) / (n << 1);
        return (wq < 0) ? -quo[31:0] : quo[31:0];
    endfunction

    // one gyro beat: sequential first-order update, then scale to unit length
    function automatic quat_t integrate(input logic signed [15:0] gx, input logic signed [15:0] gy,
                                        input logic signed [15:0] gz);
        wide_t        ax, ay, az, w, x, y, z, sq;
        logic [127:0] n, c;
        quat_t        r;
        ax = wide_t'(gx) * wide_t'({1'b0, gain});
        ay = wide_t'(gy) * wide_t'({1'b0, gain});
        az = wide_t'(gz) * wide_t'({1'b0, gain});
        w = attitude.w; x = attitude.x; y = attitude.y; z = attitude.z;
        w = clamp32(w + rate_sum(x, -ax, y, -ay, z, -az));
        x = clamp32(x + rate_sum(w, ax, y, az, z, -ay));
        y = clamp32(y + rate_sum(w, ay, x, -az, z, ax));
        z = clamp32(z + rate_sum(w, az, x, ay, y, -ax));
        sq = w * w + x * x + y * y + z * z;
        n = 0;
        for (int b = 32; b >= 0; b--) begin
            c = n | (128'd1 << b);
            if (c * c <= sq) n = c;
        end
        if (n == 0) begin
            r = '{w: Q_ONE, x: 32'sd0, y: 32'sd0, z: 32'sd0};
        end else begin
            r.w = unit_scale(w[31:0], n);
            r.x = unit_scale(x[31:0], n);
            r.y = unit_scale(y[31:0], n);
            r.z = unit_scale(z[31:0], n);
        end
        return r;
    endfunction

    task automatic compare_field(input string name, input logic signed [31:0] exp_v,
                                 input logic signed [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    initial errors = 0;
    assign pending = attitude_q.size();

    always @(posedge aclk) begin
        quat_t e;
        if (!aresetn) begin
            attitude = '{w: Q_ONE, x: 32'sd0, y: 32'sd0, z: 32'sd0};
            gain = qgi_pkg::STEP_GAIN_RESET;
            attitude_q.delete();
        end else begin
            if (cfg_we) gain = cfg_step_gain;
            if (m_valid && m_ready) begin
                if (attitude_q.size() == 0) begin
                    $error("result beat with nothing expected");
                    errors++;
                end else begin
                    e = attitude_q.pop_front();
                    compare_field("quat_w", e.w, m_quat_w);
                    compare_field("quat_x", e.x, m_quat_x);
                    compare_field("quat_y", e.y, m_quat_y);
                    compare_field("quat_z", e.z, m_quat_z);
                end
            end
            if (s_valid && s_ready) begin
                attitude = integrate(s_gyro_x, s_gyro_y, s_gyro_z);
                attitude_q.push_back(attitude);
            end
        end
    end
endmodule

FILE: sim/quaternion_gyro_integrator_tb.sv
module quaternion_gyro_integrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE = 400;
    localparam int CYCLE_LIMIT = 1000000;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_we;
    logic [23:0]          cfg_step_gain;
    logic                 s_valid;
    logic                 s_ready;
    logic signed [15:0]   s_gyro_x, s_gyro_y, s_gyro_z;
    logic                 m_valid;
    logic                 m_ready;
    logic signed [31:0]   m_quat_w, m_quat_x, m_quat_y, m_quat_z;
    int                   errors, pending;
    int                   send_idle_pct, recv_stall_pct;
    int                   cycles;

    quaternion_gyro_integrator DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_step_gain(cfg_step_gain),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_gyro_x(s_gyro_x), .s_gyro_y(s_gyro_y), .s_gyro_z(s_gyro_z),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_quat_w(m_quat_w), .m_quat_x(m_quat_x), .m_quat_y(m_quat_y), .m_quat_z(m_quat_z)
    );

    quaternion_gyro_checker checker_i (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (cycles > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_gyro(input logic signed [15:0] gx, input logic signed [15:0] gy,
                             input logic signed [15:0] gz);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_gyro_x <= gx;
        s_gyro_y <= gy;
        s_gyro_z <= gz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        // let the last accepted beat reach the checker's count
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [23:0] g);
        drain();
        cfg_we        <= 1'b1;
        cfg_step_gain <= g;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic signed [15:0] rand_count();
        case ($urandom_range(3))
            0: return 16'(signed'($urandom_range(64)) - 32);
            1: return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        int sidle[4] = '{0, 71, 0, 32};
        int rstall[4] = '{0, 0, 71, 32};
        logic [23:0] gains[4];
        cycles = 0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_step_gain = '0;
        s_valid = 1'b0;
        s_gyro_x = '0; s_gyro_y = '0; s_gyro_z = '0;
        m_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: zero rate, axis extremes, all extremes, a small mixed beat
        send_gyro(0, 0, 0);
        send_gyro(16'sh7fff, 0, 0);
        send_gyro(16'sh8000, 0, 0);
        send_gyro(0, 16'sh7fff, 0);
        send_gyro(0, 16'sh8000, 0);
        send_gyro(0, 0, 16'sh7fff);
        send_gyro(0, 0, 16'sh8000);
        send_gyro(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_gyro(16'sh8000, 16'sh8000, 16'sh8000);
        send_gyro(-1, 1, -1);
        write_gain(24'hffffff);
        // large steps to push components into saturation
        send_gyro(16'sh7fff, 16'sh8000, 16'sh7fff);
        send_gyro(16'sh8000, 16'sh7fff, 16'sh8000);
        send_gyro(16'sh7fff, 16'sh7fff, 16'sh8000);
        send_gyro(0, 0, 0);
        write_gain(24'd0);
        send_gyro(16'sh7fff, 16'sh8000, 16'sh1234);

        gains = '{qgi_pkg::STEP_GAIN_RESET, 24'hffffff, 24'd0, 24'($urandom)};
        for (int ph = 0; ph < 4; ph++) begin
            write_gain(gains[ph]);
            send_idle_pct = sidle[ph];
            recv_stall_pct = rstall[ph];
            for (int i = 0; i < 235; i++) begin
                send_gyro(rand_count(), rand_count(), rand_count());
                if (ph == 1 && i == 100) begin
                    // hold off until every result is back
                    s_valid <= 1'b0;
                    @(posedge aclk);
                    while (pending != 0) @(posedge aclk);
                end
            end
        end

        drain();
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
